// ===== design/fpa_pkg.sv =====
package fpa_pkg;

    localparam logic [3:0] OP_ADD      = 4'd0;
    localparam logic [3:0] OP_SUB      = 4'd1;
    localparam logic [3:0] OP_MUL      = 4'd2;
    localparam logic [3:0] OP_DIV      = 4'd3;
    localparam logic [3:0] OP_GT       = 4'd4;
    localparam logic [3:0] OP_LT       = 4'd5;
    localparam logic [3:0] OP_GE       = 4'd6;
    localparam logic [3:0] OP_LE       = 4'd7;
    localparam logic [3:0] OP_EQ       = 4'd8;
    localparam logic [3:0] OP_NE       = 4'd9;
    localparam logic [3:0] OP_INC      = 4'd10;
    localparam logic [3:0] OP_DEC      = 4'd11;
    localparam logic [3:0] OP_MIN      = 4'd12;
    localparam logic [3:0] OP_MAX      = 4'd13;
    localparam logic [3:0] OP_TO_INT   = 4'd14;
    localparam logic [3:0] OP_FROM_INT = 4'd15;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic        valid;
        logic [3:0]  op;
        logic        neg;
        logic [31:0] res;
        logic        cmp;
        logic        ovf;
        logic        dz;
    } side_t;

    // returns {ovf, value}
    function automatic logic [32:0] saturate(input logic neg, input logic [63:0] mag);
        logic [63:0] neg_mag;
        begin
            neg_mag = 64'd0 - mag;
            if (neg) begin
                if (mag > {32'd0, NEG_LIMIT})
                    saturate = {1'b1, NEG_LIMIT};
                else
                    saturate = {1'b0, neg_mag[31:0]};
            end
            else begin
                if (mag > {32'd0, POS_LIMIT})
                    saturate = {1'b1, POS_LIMIT};
                else
                    saturate = {1'b0, mag[31:0]};
            end
        end
    endfunction

    function automatic logic [32:0] sat_signed33(input logic [32:0] s);
        logic [32:0] m;
        begin
            m = s[32] ? (33'd0 - s) : s;
            sat_signed33 = saturate(s[32], {31'd0, m});
        end
    endfunction

endpackage

// ===== design/fixed_point_alu.sv =====
// Signed fixed-point ALU on 32-bit raw words with FRACTION_BITS fraction bits.
// Input channel: an item (operation, operand_a, operand_b) is taken on a rising
// edge where start is high and busy is low. busy is always low: the pipeline
// takes one item every cycle.
// Result channel: done is high for one cycle with result_value, compare_true,
// overflow and divide_by_zero; the receiver cannot stall, so none is needed.
// Every operation takes the same path from accepting edge to the done cycle,
// so items leave in order.
// Throughput: one item per cycle. Depth is set by the bit-per-stage restoring
// divider (32 + FRACTION_BITS stages plus a rounding stage); the other
// operations ride along in a matching delay line.
// Multiply uses one 32x32 multiplier, registered, then rounded in the next
// stage. Mul, div and to_int round to nearest, ties away from zero; results
// that leave the 32-bit range saturate and raise overflow.
// Reset clears all valid bits; no done pulse appears until items are issued.
module fixed_point_alu #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  operation,
    input  logic signed [31:0] operand_a,
    input  logic signed [31:0] operand_b,
    output logic        done,
    output logic signed [31:0] result_value,
    output logic        compare_true,
    output logic        overflow,
    output logic        divide_by_zero
);

    localparam int NW = 32 + FRACTION_BITS;
    localparam logic [63:0] HALF = (64'd1 << FRACTION_BITS) >> 1;

    // stage 1: input registers
    logic        v1_reg;
    logic [3:0]  op1_reg;
    logic [31:0] a1_reg;
    logic [31:0] b1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        op1_reg <= operation;
        a1_reg  <= operand_a;
        b1_reg  <= operand_b;
    end

    // stage 2: simple ops, multiply, divider operands
    logic [31:0]   ma;
    logic [31:0]   mb;
    logic          lt;
    logic [32:0]   sum;
    logic [32:0]   dif;
    logic [32:0]   incv;
    logic [32:0]   decv;
    logic [32:0]   sat;
    logic [NW-1:0] n_next;
    fpa_pkg::side_t side2_next;

    fpa_pkg::side_t side2_reg;
    logic [63:0]    prod2_reg;
    logic [NW-1:0]  n2_reg;
    logic [31:0]    mb2_reg;

    always_comb
    begin
        ma   = a1_reg[31] ? (32'd0 - a1_reg) : a1_reg;
        mb   = b1_reg[31] ? (32'd0 - b1_reg) : b1_reg;
        lt   = ($signed(a1_reg) < $signed(b1_reg));
        sum  = {a1_reg[31], a1_reg} + {b1_reg[31], b1_reg};
        dif  = {a1_reg[31], a1_reg} - {b1_reg[31], b1_reg};
        incv = {a1_reg[31], a1_reg} + 33'd1;
        decv = {a1_reg[31], a1_reg} - 33'd1;
        n_next = NW'(ma) << FRACTION_BITS;
        sat  = '0;

        side2_next       = '0;
        side2_next.valid = v1_reg;
        side2_next.op    = op1_reg;
        side2_next.neg   = a1_reg[31] ^ b1_reg[31];

        case (op1_reg)
            fpa_pkg::OP_ADD:  sat = fpa_pkg::sat_signed33(sum);
            fpa_pkg::OP_SUB:  sat = fpa_pkg::sat_signed33(dif);
            fpa_pkg::OP_INC:  sat = fpa_pkg::sat_signed33(incv);
            fpa_pkg::OP_DEC:  sat = fpa_pkg::sat_signed33(decv);
            fpa_pkg::OP_TO_INT:
                sat = fpa_pkg::saturate(a1_reg[31], ({32'd0, ma} + HALF) >> FRACTION_BITS);
            fpa_pkg::OP_FROM_INT:
                sat = fpa_pkg::saturate(a1_reg[31], {32'd0, ma} << FRACTION_BITS);
            fpa_pkg::OP_MIN:  sat = {1'b0, lt ? a1_reg : b1_reg};
            fpa_pkg::OP_MAX:  sat = {1'b0, (!lt && a1_reg != b1_reg) ? a1_reg : b1_reg};
            fpa_pkg::OP_GT:   side2_next.cmp = !lt && (a1_reg != b1_reg);
            fpa_pkg::OP_LT:   side2_next.cmp = lt;
            fpa_pkg::OP_GE:   side2_next.cmp = !lt;
            fpa_pkg::OP_LE:   side2_next.cmp = lt || (a1_reg == b1_reg);
            fpa_pkg::OP_EQ:   side2_next.cmp = (a1_reg == b1_reg);
            fpa_pkg::OP_NE:   side2_next.cmp = (a1_reg != b1_reg);
            fpa_pkg::OP_DIV:  side2_next.dz  = (mb == 32'd0);
            default:          sat = '0;
        endcase

        side2_next.res = sat[31:0];
        side2_next.ovf = sat[32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side2_reg <= '0;
        else
            side2_reg <= side2_next;
    end

    always_ff @(posedge clk)
    begin
        prod2_reg <= {32'd0, ma} * {32'd0, mb};
        n2_reg    <= n_next;
        mb2_reg   <= mb;
    end

    // divider
    logic [NW:0] div_mag;

    fpa_div #(
        .NW (NW)
    ) u_div (
        .clk (clk),
        .n   (n2_reg),
        .d   (mb2_reg),
        .mag (div_mag)
    );

    // side delay line; first stage finishes the multiply
    fpa_pkg::side_t sd_reg [NW+1];
    fpa_pkg::side_t sd0_next;
    logic [32:0]    mul_sat;

    always_comb
    begin
        mul_sat  = fpa_pkg::saturate(side2_reg.neg, (prod2_reg + HALF) >> FRACTION_BITS);
        sd0_next = side2_reg;
        if (side2_reg.op == fpa_pkg::OP_MUL)
        begin
            sd0_next.res = mul_sat[31:0];
            sd0_next.ovf = mul_sat[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NW; i++)
                sd_reg[i] <= '0;
        end
        else
        begin
            sd_reg[0] <= sd0_next;
            for (int i = 1; i <= NW; i++)
                sd_reg[i] <= sd_reg[i-1];
        end
    end

    // output stage
    fpa_pkg::side_t last;
    logic [32:0]    div_sat;
    logic           done_reg;
    logic [31:0]    res_reg;
    logic           cmp_reg;
    logic           ovf_reg;
    logic           dz_reg;
    logic [31:0]    res_next;
    logic           ovf_next;

    always_comb
    begin
        last     = sd_reg[NW];
        div_sat  = fpa_pkg::saturate(last.neg, 64'(div_mag));
        res_next = last.res;
        ovf_next = last.ovf;
        if (last.op == fpa_pkg::OP_DIV && !last.dz)
        begin
            res_next = div_sat[31:0];
            ovf_next = div_sat[32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= last.valid;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        cmp_reg <= last.cmp;
        ovf_reg <= ovf_next;
        dz_reg  <= last.dz;
    end

    assign busy           = 1'b0;
    assign done           = done_reg;
    assign result_value   = res_reg;
    assign compare_true   = cmp_reg;
    assign overflow       = ovf_reg;
    assign divide_by_zero = dz_reg;

endmodule

// ===== design/fpa_div.sv =====
module fpa_div #(
    parameter int NW = 40
) (
    input  logic          clk,
    input  logic [NW-1:0] n,
    input  logic [31:0]   d,
    output logic [NW:0]   mag
);

    logic [31:0]   r_reg [NW];
    logic [NW-1:0] n_reg [NW];
    logic [NW-1:0] q_reg [NW];
    logic [31:0]   d_reg [NW];
    logic [NW:0]   mag_reg;

    genvar k;
    generate
        for (k = 0; k < NW; k++) begin : g_stage
            logic [31:0]   r_prev;
            logic [NW-1:0] n_prev;
            logic [NW-1:0] q_prev;
            logic [31:0]   d_prev;
            logic [32:0]   trial;
            logic [32:0]   diff;
            logic          ge;
            logic [31:0]   r_next;
            logic [NW-1:0] n_next;
            logic [NW-1:0] q_next;

            if (k == 0) begin : g_first
                assign r_prev = 32'd0;
                assign n_prev = n;
                assign q_prev = '0;
                assign d_prev = d;
            end
            else begin : g_rest
                assign r_prev = r_reg[k-1];
                assign n_prev = n_reg[k-1];
                assign q_prev = q_reg[k-1];
                assign d_prev = d_reg[k-1];
            end

            always_comb
            begin
                trial  = {r_prev, n_prev[NW-1]};
                diff   = trial - {1'b0, d_prev};
                ge     = (trial >= {1'b0, d_prev});
                r_next = ge ? diff[31:0] : trial[31:0];
                n_next = n_prev << 1;
                q_next = {q_prev[NW-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                r_reg[k] <= r_next;
                n_reg[k] <= n_next;
                q_reg[k] <= q_next;
                d_reg[k] <= d_prev;
            end
        end
    endgenerate

    // round to nearest: bump when 2*rem >= divisor
    always_ff @(posedge clk)
    begin
        mag_reg <= {1'b0, q_reg[NW-1]}
                 + (NW+1)'({r_reg[NW-1], 1'b0} >= {1'b0, d_reg[NW-1]});
    end

    assign mag = mag_reg;

endmodule
